/* rtl/radix_ascii_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// radix_ascii_converter_core_defines
// Assertion macros shared by the radix converter RTL. They expect signals
// named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef RADIX_ASCII_CONVERTER_CORE_DEFINES_SVH
`define RADIX_ASCII_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define RAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rac: same-cycle check failed");

// next-cycle implication, off during reset
`define RAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rac: next-cycle check failed");

`endif

/* rtl/rac_pkg.sv */
// ----------------------------------------------------------------------------
// rac_pkg
// Constants, types and helper functions of the radix converter.
// ----------------------------------------------------------------------------
package rac_pkg;

  // sizing
  localparam int MAX_BASE    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int ALPHA_W     = 64;
  localparam int NUM_CHARS   = 16;
  localparam int DIGIT_W     = $clog2(MAX_BASE);

  // divider: quotient bits retired per cycle
  localparam int STEPS   = 8;
  localparam int DIV_CYC = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int DIVW    = DIV_CYC * STEPS;
  localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  // digit stack
  localparam int STK_AW = $clog2(VALUE_WIDTH);
  localparam int SP_W   = $clog2(VALUE_WIDTH + 1);

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // special characters
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_LEN = 2'd0,
    CFG_ALPHA_LO = 2'd1,
    CFG_ALPHA_HI = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_len;
    logic [ALPHA_W-1:0] alpha_lo;
    logic [ALPHA_W-1:0] alpha_hi;
  } rac_cfg_t;

  // one classified value waiting for conversion
  typedef struct packed {
    logic            neg;
    logic [DIVW-1:0] mag;
  } rac_item_t;

  // alphabet character k
  function automatic logic [CHAR_W-1:0] char_at(rac_cfg_t cfg, logic [3:0] idx);
    logic [2*ALPHA_W-1:0] alph;
    alph = {cfg.alpha_hi, cfg.alpha_lo};
    return alph[idx*CHAR_W +: CHAR_W];
  endfunction

  // length in range, no sign characters, no repeats
  function automatic logic alpha_ok(rac_cfg_t cfg);
    logic ok;
    logic [CHAR_W-1:0] ci;
    logic [CHAR_W-1:0] cj;
    ok = (cfg.base_len >= BASE_W'(2)) && (cfg.base_len <= BASE_W'(MAX_BASE));
    for (int i = 0; i < NUM_CHARS; i++) begin
      ci = char_at(cfg, 4'(i));
      if (i < int'(cfg.base_len)) begin
        if ((ci == CHAR_PLUS) || (ci == CHAR_MINUS)) ok = 1'b0;
        for (int j = 0; j < NUM_CHARS; j++) begin
          cj = char_at(cfg, 4'(j));
          if ((j > i) && (j < int'(cfg.base_len)) && (ci == cj)) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

/* rtl/rac_front.sv */
// ----------------------------------------------------------------------------
// rac_front
// Takes a start command, checks the alphabet and forms sign and magnitude.
// Values under an invalid alphabet are dropped here.
// ----------------------------------------------------------------------------
module rac_front import rac_pkg::*; (
  input  logic                   start,
  input  logic                   q_full,
  input  logic signed [IN_W-1:0] in_value,
  input  rac_cfg_t               cfg,
  output logic                   push,
  output rac_item_t              push_item
);

  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] magw;
  logic                   neg;

  // two's complement magnitude, most negative value comes out as 2^(w-1)
  assign v    = in_value[VALUE_WIDTH-1:0];
  assign neg  = v[VALUE_WIDTH-1];
  assign magw = neg ? VALUE_WIDTH'(~v + 1'b1) : v;

  // enqueue only when the alphabet gives output
  assign push           = start && !q_full && alpha_ok(cfg);
  assign push_item.neg  = neg;
  assign push_item.mag  = DIVW'(magw);

endmodule

/* rtl/rac_fifo.sv */
// ----------------------------------------------------------------------------
// rac_fifo
// Short queue of classified values between front and back.
// ----------------------------------------------------------------------------
module rac_fifo import rac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rac_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output rac_item_t pop_item
);

  rac_item_t         mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r;
  logic [QAW-1:0]    rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/rac_back.sv */
// ----------------------------------------------------------------------------
// rac_back
// Converts one magnitude by repeated division by the radix, stacks the
// digits and sends them most significant first, after the sign.
// ----------------------------------------------------------------------------
module rac_back import rac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rac_cfg_t          cfg,
  input  logic              pop_valid,
  input  rac_item_t         pop_item,
  output logic              pop,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SIGN = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t        state_r;
  back_state_t        state_nxt;
  logic [DIVW-1:0]    quo_r;
  logic [DIVW-1:0]    quo_nxt;
  logic [DIGIT_W-1:0] rem_r;
  logic [DIGIT_W-1:0] rem_div;
  logic [STEPS-1:0]   qbits;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   radix;
  logic [CYC_W-1:0]   cyc_r;
  logic               cyc_last;
  logic               neg_r;
  logic [SP_W-1:0]    sp_r;
  logic [SP_W-1:0]    sp_m1;
  logic [DIGIT_W-1:0] stk_r [VALUE_WIDTH];
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  assign radix    = cfg.base_len[DIGIT_W:0];
  assign cyc_last = (cyc_r == CYC_W'(DIV_CYC - 1));
  assign sp_m1    = sp_r - SP_W'(1);
  assign pop      = (state_r == B_IDLE) && pop_valid;

  // restoring division slice: STEPS quotient bits per cycle
  always_comb begin
    rem_div = rem_r;
    qbits   = '0;
    trial   = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial = {rem_div, quo_r[DIVW-1-k]};
      if (trial >= radix) begin
        rem_div            = DIGIT_W'(trial - radix);
        qbits[STEPS-1-k]   = 1'b1;
      end else begin
        rem_div = trial[DIGIT_W-1:0];
      end
    end
    quo_nxt = (quo_r << STEPS) | DIVW'(qbits);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_DIV;
      B_DIV: begin
        if (cyc_last && (quo_nxt == '0)) state_nxt = neg_r ? B_SIGN : B_EMIT;
      end
      B_SIGN: state_nxt = B_EMIT;
      B_EMIT: if (sp_r == SP_W'(1)) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cyc_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == B_SIGN) || (state_r == B_EMIT);
      unique case (state_r)
        B_IDLE: begin
          cyc_r <= '0;
          sp_r  <= '0;
        end
        B_DIV: begin
          cyc_r <= cyc_last ? '0 : cyc_r + CYC_W'(1);
          if (cyc_last) sp_r <= sp_r + SP_W'(1);
        end
        B_SIGN: ;
        B_EMIT: sp_r <= sp_m1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        quo_r <= pop_item.mag;
        neg_r <= pop_item.neg;
        rem_r <= '0;
      end
      B_DIV: begin
        quo_r <= quo_nxt;
        rem_r <= cyc_last ? '0 : rem_div;
        if (cyc_last) stk_r[sp_r[STK_AW-1:0]] <= rem_div;
      end
      B_SIGN: begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end
      B_EMIT: begin
        out_char_r <= char_at(cfg, 4'(stk_r[sp_m1[STK_AW-1:0]]));
        out_last_r <= (sp_r == SP_W'(1));
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/radix_ascii_converter_core.sv */
// ----------------------------------------------------------------------------
// radix_ascii_converter_core
// Writes a signed value as characters of a configured alphabet and radix.
//
//   channel  ports                                  handshake
//   input    start, busy, in_value                  start && !busy
//   result   out_valid, out_char, out_last          out_valid, one cycle
//   config   cfg_valid, cfg_ready, cfg_index/data   cfg_valid && cfg_ready
//
// A value is loaded from the queue, then divided by the radix once per digit,
// each division retiring 8 quotient bits a cycle across the 32-bit magnitude,
// then its characters are sent one per cycle, sign included.
// busy is high while the two-entry queue in front of the divider is full.
// Reset is synchronous; it clears control and configuration, not the datapath.
// Results are never held back; the receiver must take each one.
// ----------------------------------------------------------------------------
`include "radix_ascii_converter_core_defines.svh"

module radix_ascii_converter_core import rac_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_value,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [ALPHA_W-1:0]     cfg_data
);

  rac_cfg_t  cfg_r;
  logic      q_full;
  logic      push;
  rac_item_t push_item;
  logic      pop;
  logic      pop_valid;
  rac_item_t pop_item;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_LEN: cfg_r.base_len <= cfg_data[BASE_W-1:0];
        CFG_ALPHA_LO: cfg_r.alpha_lo <= cfg_data;
        CFG_ALPHA_HI: cfg_r.alpha_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  rac_front u_front (
    .start     (start),
    .q_full    (q_full),
    .in_value  (in_value),
    .cfg       (cfg_r),
    .push      (push),
    .push_item (push_item)
  );

  // queue between front and back
  rac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // back: divide and send
  rac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  // checks
  `RAC_ASSERT_IMP(a_minus_not_last, out_valid && (out_char == CHAR_MINUS), !out_last)
  `RAC_ASSERT_NXT(a_minus_then_digit, out_valid && (out_char == CHAR_MINUS), out_valid)
  `RAC_ASSERT_IMP(a_busy_after_start, $rose(busy), $past(start))

endmodule
